// File: rtl/mpbr_pkg.sv
// Shared types and constants of the mesh path broadcast router.
// Used by the divider, the top level and the port checker; has no dependencies.
package mpbr_pkg;

   // Widths of the header fields and of the configuration registers.
   localparam int ID_W      = 8;
   localparam int CFG_W     = 5;
   localparam int DIR_W     = 2;
   localparam int COUNT_W   = 2;
   localparam int DIV_HALF  = ID_W / 2;

   // Default and reset values of the mesh dimensions.
   localparam int MAX_DIM_DEF = 16;
   localparam logic [CFG_W-1:0] RESET_DIM = CFG_W'(4);

   // Stream and register port widths.
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - COUNT_W - 2 * DIR_W;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Register index, taken from the word address bit.
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   // Output port directions.
   typedef enum logic [DIR_W-1:0] {
      DIR_NORTH = 2'd0,
      DIR_EAST  = 2'd1,
      DIR_SOUTH = 2'd2,
      DIR_WEST  = 2'd3
   } dir_type;

   // Load enables of the two divider stages.
   typedef struct packed {
      logic load_hi;
      logic load_lo;
   } div_ctrl_type;

endpackage

// File: rtl/mpbr_divider.sv
// Two-stage restoring divider that splits a node id into column and row.
// Depends on mpbr_pkg; the top level supplies the load enables.
module mpbr_divider
   import mpbr_pkg::*;
#(
   parameter int DIM_W = 5
) (
   input  logic               clock,
   input  div_ctrl_type       ctrl,
   input  logic [ID_W-1:0]    dividend,
   input  logic [DIM_W-1:0]   divisor,
   output logic [ID_W-1:0]    quot,
   output logic [DIM_W-1:0]   rem
);

   localparam int RW = DIM_W + 1;

   logic [DIM_W-1:0]    hi_rem_ff, hi_rem_in;
   logic [DIV_HALF-1:0] hi_q_ff, hi_q_in;
   logic [DIV_HALF-1:0] lo_bits_ff, lo_bits_in;
   logic [ID_W-1:0]     quot_ff, quot_in;
   logic [DIM_W-1:0]    rem_ff, rem_in;

   // Upper half of the quotient: one compare and subtract per dividend bit.
   always_comb begin
      logic [RW-1:0] part;
      logic [DIM_W-1:0] r;
      r = '0;
      hi_q_in = '0;
      for (int i = 0; i < DIV_HALF; i++) begin
         part = {r, dividend[ID_W-1-i]};
         if (part >= {1'b0, divisor}) begin
            part = part - {1'b0, divisor};
            hi_q_in[DIV_HALF-1-i] = 1'b1;
         end
         r = part[DIM_W-1:0];
      end
      hi_rem_in  = r;
      lo_bits_in = dividend[DIV_HALF-1:0];
   end

   // Lower half continues from the partial remainder of the first stage.
   always_comb begin
      logic [RW-1:0] part;
      logic [DIM_W-1:0] r;
      logic [DIV_HALF-1:0] q;
      r = hi_rem_ff;
      q = '0;
      for (int i = 0; i < DIV_HALF; i++) begin
         part = {r, lo_bits_ff[DIV_HALF-1-i]};
         if (part >= {1'b0, divisor}) begin
            part = part - {1'b0, divisor};
            q[DIV_HALF-1-i] = 1'b1;
         end
         r = part[DIM_W-1:0];
      end
      quot_in = {hi_q_ff, q};
      rem_in  = r;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_hi) begin
         hi_rem_ff  <= hi_rem_in;
         hi_q_ff    <= hi_q_in;
         lo_bits_ff <= lo_bits_in;
      end
      if (ctrl.load_lo) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// File: rtl/mesh_path_broadcast_router.sv
// Output direction computation for a 2D mesh router (XY unicast, snake broadcast).
// Depends on mpbr_pkg and instantiates mpbr_divider three times.
//
// Usage: the req_ stream carries one packet header per word: the current
// node, the source node and the destination node in tdata, and the
// broadcast flag in tuser. For every accepted word the rsp_ stream returns
// one word with the number of directions (0 to 2) and the directions
// themselves (0 north, 1 east, 2 south, 3 west); unused fields are zero.
// The mesh size is set through the csr_ register port (width at address 0,
// height at address 4) and should only change while no header is in flight.
// Throughput: one word per cycle while rsp_tready holds; the five register
// stages are two divider stages, a multiplier stage, a label adder stage
// and an output stage holding the final compares.
// Reset clears all stage valid bits and sets both dimensions to 4.
// When the receiver stalls, each stage holds its word and ready ripples
// back only as far as the first empty stage, so bubbles are filled first.
module mesh_path_broadcast_router
   import mpbr_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: current_node, source_node, dest_node (from bit 0 up)
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: is_broadcast
   input  logic                   req_tuser,
   // rsp_tdata: dir_count, first_dir, second_dir, zero padding (from bit 0 up)
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // Register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int PW    = ID_W + DIM_W;
   localparam int LW    = ID_W + 2 * DIM_W;
   localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

   // Configuration registers.
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         if (csr_paddr[2] == CSR_IDX_WIDTH) begin
            width_in = csr_pwdata[CFG_W-1:0];
         end else begin
            height_in = csr_pwdata[CFG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_DIM;
         height_ff <= RESET_DIM;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_WIDTH) ? CSR_DATA_W'(width_ff)
                                                       : CSR_DATA_W'(height_ff);

   // Effective dimensions: zero counts as one, large values saturate.
   logic [DIM_W-1:0] w_eff, h_eff;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (32'(width_ff) > 32'(MAX_DIM)) begin
         w_eff = MAX_DIM_V;
      end else begin
         w_eff = DIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (32'(height_ff) > 32'(MAX_DIM)) begin
         h_eff = MAX_DIM_V;
      end else begin
         h_eff = DIM_W'(height_ff);
      end
   end

   // Last label on the snake path, refreshed every cycle.
   logic [LW-1:0] last_ff, last_in;

   assign last_in = LW'(w_eff) * LW'(h_eff) - LW'(1);

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   // Stage handshake: a stage loads when it is empty or its successor loads.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5 = !v5_ff || rsp_tready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;

   assign v1_in = rdy1 ? req_tvalid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;
   assign v5_in = rdy5 ? v4_ff : v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // Stages one and two: split the three node ids into column and row.
   div_ctrl_type     div_ctrl;
   logic [ID_W-1:0]  cy, sy, dy;
   logic [DIM_W-1:0] cx, sx, dx;

   assign div_ctrl.load_hi = rdy1 && req_tvalid;
   assign div_ctrl.load_lo = rdy2 && v1_ff;

   mpbr_divider #(.DIM_W(DIM_W)) u_div_cur (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (req_tdata[ID_W-1:0]),
      .divisor  (w_eff),
      .quot     (cy),
      .rem      (cx)
   );

   mpbr_divider #(.DIM_W(DIM_W)) u_div_src (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (req_tdata[2*ID_W-1:ID_W]),
      .divisor  (w_eff),
      .quot     (sy),
      .rem      (sx)
   );

   mpbr_divider #(.DIM_W(DIM_W)) u_div_dst (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (req_tdata[3*ID_W-1:2*ID_W]),
      .divisor  (w_eff),
      .quot     (dy),
      .rem      (dx)
   );

   // Broadcast flag travels alongside the divider.
   logic bc1_ff, bc1_in, bc2_ff, bc2_in;

   assign bc1_in = req_tuser;
   assign bc2_in = bc1_ff;

   always_ff @(posedge clock) begin
      if (div_ctrl.load_hi) begin
         bc1_ff <= bc1_in;
      end
      if (div_ctrl.load_lo) begin
         bc2_ff <= bc2_in;
      end
   end

   // Stage three: row products, unicast direction and snake neighbour directions.
   logic [PW-1:0]    prodc3_ff, prodc3_in, prods3_ff, prods3_in;
   logic [DIM_W-1:0] cx3_ff, cx3_in, sx3_ff, sx3_in;
   logic             codd3_ff, codd3_in, sodd3_ff, sodd3_in, bc3_ff, bc3_in;
   dir_type          udir3_ff, udir3_in, ndir3_ff, ndir3_in, pdir3_ff, pdir3_in;
   logic             at_left, at_right;

   assign at_left  = (cx == '0);
   assign at_right = (cx == w_eff - DIM_W'(1));

   always_comb begin
      prodc3_in = PW'(cy) * PW'(w_eff);
      prods3_in = PW'(sy) * PW'(w_eff);
      cx3_in    = cx;
      sx3_in    = sx;
      codd3_in  = cy[0];
      sodd3_in  = sy[0];
      bc3_in    = bc2_ff;

      // XY order: east, west, south, otherwise north.
      if (dx > cx) begin
         udir3_in = DIR_EAST;
      end else if (dx < cx) begin
         udir3_in = DIR_WEST;
      end else if (dy > cy) begin
         udir3_in = DIR_SOUTH;
      end else begin
         udir3_in = DIR_NORTH;
      end

      // Even rows run eastward along the path, odd rows westward.
      if (!cy[0]) begin
         ndir3_in = at_right ? DIR_SOUTH : DIR_EAST;
         pdir3_in = at_left  ? DIR_NORTH : DIR_WEST;
      end else begin
         ndir3_in = at_left  ? DIR_SOUTH : DIR_WEST;
         pdir3_in = at_right ? DIR_NORTH : DIR_EAST;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         prodc3_ff <= prodc3_in;
         prods3_ff <= prods3_in;
         cx3_ff    <= cx3_in;
         sx3_ff    <= sx3_in;
         codd3_ff  <= codd3_in;
         sodd3_ff  <= sodd3_in;
         bc3_ff    <= bc3_in;
         udir3_ff  <= udir3_in;
         ndir3_ff  <= ndir3_in;
         pdir3_ff  <= pdir3_in;
      end
   end

   // Stage four: snake labels of the current and the source node.
   logic [LW-1:0] cl4_ff, cl4_in, sl4_ff, sl4_in;
   logic          bc4_ff, bc4_in;
   dir_type       udir4_ff, udir4_in, ndir4_ff, ndir4_in, pdir4_ff, pdir4_in;

   always_comb begin
      if (codd3_ff) begin
         cl4_in = LW'(prodc3_ff) + LW'(w_eff) - LW'(cx3_ff) - LW'(1);
      end else begin
         cl4_in = LW'(prodc3_ff) + LW'(cx3_ff);
      end
      if (sodd3_ff) begin
         sl4_in = LW'(prods3_ff) + LW'(w_eff) - LW'(sx3_ff) - LW'(1);
      end else begin
         sl4_in = LW'(prods3_ff) + LW'(sx3_ff);
      end
      bc4_in   = bc3_ff;
      udir4_in = udir3_ff;
      ndir4_in = ndir3_ff;
      pdir4_in = pdir3_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         cl4_ff   <= cl4_in;
         sl4_ff   <= sl4_in;
         bc4_ff   <= bc4_in;
         udir4_ff <= udir4_in;
         ndir4_ff <= ndir4_in;
         pdir4_ff <= pdir4_in;
      end
   end

   // Stage five: path position compares and the result word.
   logic [COUNT_W-1:0] count5_ff, count5_in;
   dir_type            first5_ff, first5_in, second5_ff, second5_in;
   logic               fwd, bwd;

   assign fwd = (cl4_ff >= sl4_ff) && (cl4_ff < last_ff);
   assign bwd = (cl4_ff <= sl4_ff) && (cl4_ff != '0);

   always_comb begin
      if (bc4_ff) begin
         count5_in  = COUNT_W'(fwd) + COUNT_W'(bwd);
         first5_in  = fwd ? ndir4_ff : (bwd ? pdir4_ff : DIR_NORTH);
         second5_in = (fwd && bwd) ? pdir4_ff : DIR_NORTH;
      end else begin
         count5_in  = COUNT_W'(1);
         first5_in  = udir4_ff;
         second5_in = DIR_NORTH;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5 && v4_ff) begin
         count5_ff  <= count5_in;
         first5_ff  <= first5_in;
         second5_ff <= second5_in;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, second5_ff, first5_ff, count5_ff};

endmodule

// File: rtl/mpbr_checker.sv
// Port-level checks on the result stream of the mesh path broadcast router.
// Depends on mpbr_pkg; bound to mesh_path_broadcast_router at the end of this file.
module mpbr_checker
   import mpbr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // No word leaves the block in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid straight after reset");

   // A stalled word is held unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // At most two directions are ever reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("direction count above two");

   // Unused direction fields read as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:4] == 2'd0 || rsp_tdata[1:0] == 2'd2)
                  && (rsp_tdata[3:2] == 2'd0 || rsp_tdata[1:0] != 2'd0))
      else $error("unused direction field not zero");

   // The two path neighbours always lie in different directions.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == 2'd2 |-> rsp_tdata[3:2] != rsp_tdata[5:4])
      else $error("both broadcast directions are the same");

endmodule

bind mesh_path_broadcast_router mpbr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
